### hdl/bbl_pkg.sv
// ----------------------------------------------------------------------------
// bbl_pkg: shared types and constants of the 3x3 box blur stream
// Holds the field widths, the result record, the divide-by-nine constants
// and the inter-stage struct shared by the datapath modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bbl_pkg;

    // Default capacity of the line stores and of the row counter.
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Fixed field widths of the ports.
    localparam int PIX_W     = 8;
    localparam int POS_W     = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    // Reset values of the frame size registers.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // Window sum: nine 8-bit pixels plus the rounding term stay below 2^12.
    localparam int SUM_W = 12;
    localparam logic [SUM_W-1:0] ROUND = 12'd4;

    // (s * 7282) >> 16 equals s / 9 for every s below 2300.
    localparam int DIV9_MUL_W = 13;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
    localparam int DIV9_SHIFT = 16;
    localparam int PROD_W = SUM_W + DIV9_MUL_W;

    // Result queue geometry.
    localparam int Q_DEPTH   = 8;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int CNT_W     = Q_AW + 1;
    localparam int OCC_W     = CNT_W + 1;
    localparam int RES_SLOTS = 3;

    // Which results one input pixel causes.
    typedef struct packed {
        logic first_row;
        logic interior;
        logic right_edge;
        logic left_edge;
        logic last_row;
        logic end_frame;
    } t_flags;

    // Row and column labels of the pixel, already cut to the output width.
    typedef struct packed {
        logic [POS_W-1:0] row_cur;
        logic [POS_W-1:0] row_prev;
        logic [POS_W-1:0] col_cur;
        logic [POS_W-1:0] col_prev;
    } t_pos;

    // Window stage to result stage.
    typedef struct packed {
        logic             valid;
        t_pos             pos;
        t_flags           flags;
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] left_pixel;
        logic [SUM_W-1:0] sum;
    } t_stage;

    // One output pixel.
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic [PIX_W-1:0] value;
        logic             end_frame;
    } t_res;

    // All results of one input pixel, slot 0 first.
    typedef struct packed {
        t_res [RES_SLOTS-1:0] slot;
        logic [1:0]           cnt;
    } t_rec;

endpackage

`default_nettype wire

### hdl/bbl_ram.sv
// ----------------------------------------------------------------------------
// bbl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/bbl_line_window.sv
// ----------------------------------------------------------------------------
// bbl_line_window: position counters, line stores and the 3x3 window
// Reads both line stores at the current column, shifts the window in the
// next cycle, writes the column back and registers the window sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bbl_line_window #(
    parameter int MAX_WIDTH  = bbl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbl_pkg::MAX_HEIGHT_DEF,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int RW         = $clog2(MAX_HEIGHT)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [bbl_pkg::PIX_W-1:0] i_pixel,
    input  wire logic [CW-1:0]             i_wm1,
    input  wire logic [RW-1:0]             i_hm1,
    output bbl_pkg::t_stage                o_stage,
    output logic      [1:0]                o_inflight
);

    import bbl_pkg::*;

    // Position counters.
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] x;
    logic [RW-1:0] y;
    logic          at_row_end;
    t_flags        flags;
    t_pos          pos;

    // Read stage.
    logic             r_a_valid;
    logic [CW-1:0]    r_a_x;
    logic [PIX_W-1:0] r_a_pixel;
    t_flags           r_a_flags;
    t_pos             r_a_pos;

    // Line store read data.
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;

    // Window: the middle and right columns, rows top to bottom.
    logic [PIX_W-1:0] r_mcol [3];
    logic [PIX_W-1:0] r_rcol [3];
    logic [PIX_W-1:0] r_left;
    logic [SUM_W-1:0] sum;

    t_stage r_stage;

    // Counters saturate when the frame was made smaller.
    always_comb begin
        x = (r_col > i_wm1) ? i_wm1 : r_col;
        y = (r_row > i_hm1) ? i_hm1 : r_row;
        at_row_end = (x == i_wm1);

        flags.first_row  = (y == '0);
        flags.interior   = (y > RW'(1)) && (x > CW'(1));
        flags.right_edge = (y > RW'(1)) && at_row_end;
        flags.left_edge  = (y != '0) && (y < i_hm1) && at_row_end;
        flags.last_row   = (y == i_hm1);
        flags.end_frame  = (y == i_hm1) && at_row_end;

        pos.row_cur  = POS_W'(y);
        pos.row_prev = POS_W'(y - 1'b1);
        pos.col_cur  = POS_W'(x);
        pos.col_prev = POS_W'(x - 1'b1);

        if (at_row_end) begin
            n_col = '0;
            n_row = (y >= i_hm1) ? '0 : y + 1'b1;
        end else begin
            n_col = x + 1'b1;
            n_row = y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_accept;
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_x     <= x;
            r_a_pixel <= i_pixel;
            r_a_flags <= flags;
            r_a_pos   <= pos;
        end
    end

    // Consecutive pixels always use different columns (the width is at least
    // three), so the write-back never meets a read of the same entry.
    bbl_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_two_above (
        .i_clk     (i_clk),
        .i_wr_en   (r_a_valid),
        .i_wr_addr (r_a_x),
        .i_wr_data (mid),
        .i_rd_en   (i_accept),
        .i_rd_addr (x),
        .o_rd_data (top)
    );

    bbl_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_one_above (
        .i_clk     (i_clk),
        .i_wr_en   (r_a_valid),
        .i_wr_addr (r_a_x),
        .i_wr_data (r_a_pixel),
        .i_rd_en   (i_accept),
        .i_rd_addr (x),
        .o_rd_data (mid)
    );

    assign sum = SUM_W'(r_mcol[0]) + SUM_W'(r_mcol[1]) + SUM_W'(r_mcol[2])
               + SUM_W'(r_rcol[0]) + SUM_W'(r_rcol[1]) + SUM_W'(r_rcol[2])
               + SUM_W'(top) + SUM_W'(mid) + SUM_W'(r_a_pixel);

    // The stage payload is not reset; only its valid bit is.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_mcol[k] <= '0;
                r_rcol[k] <= '0;
            end
            r_left <= '0;
        end else begin
            r_stage.valid <= r_a_valid;
            if (r_a_valid) begin
                r_mcol[0] <= r_rcol[0];
                r_mcol[1] <= r_rcol[1];
                r_mcol[2] <= r_rcol[2];
                r_rcol[0] <= top;
                r_rcol[1] <= mid;
                r_rcol[2] <= r_a_pixel;
                if (r_a_x == '0) begin
                    r_left <= r_a_pixel;
                end
                r_stage.pos        <= r_a_pos;
                r_stage.flags      <= r_a_flags;
                r_stage.pixel      <= r_a_pixel;
                r_stage.mid        <= mid;
                r_stage.left_pixel <= r_left;
                r_stage.sum        <= sum;
            end
        end
    end

    assign o_stage    = r_stage;
    assign o_inflight = {1'b0, r_a_valid} + {1'b0, r_stage.valid};

endmodule

`default_nettype wire

### hdl/bbl_result_queue.sv
// ----------------------------------------------------------------------------
// bbl_result_queue: mean division, result packing and output queue
// Turns one window stage entry into up to three results, queues them as one
// record and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module bbl_result_queue (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  bbl_pkg::t_stage                i_stage,
    output logic      [bbl_pkg::CNT_W-1:0] o_count,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output bbl_pkg::t_res                  o_res,
    output logic                           o_last
);

    import bbl_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  blur;
    t_res              cand [5];
    logic [4:0]        cand_en;
    logic [1:0]        n;
    t_rec              rec;
    logic              push;
    logic              pop;
    logic              xfer;

    t_rec             r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr;
    logic [Q_AW-1:0]  r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       r_sub;
    t_rec             head;

    assign prod = PROD_W'(i_stage.sum + ROUND) * PROD_W'(DIV9_MUL);
    assign blur = PIX_W'(prod >> DIV9_SHIFT);

    // Candidates in output order: first row, interior, right border,
    // left border of the next row, last row.
    always_comb begin
        cand[0] = '{row: i_stage.pos.row_cur, column: i_stage.pos.col_cur,
                    value: i_stage.pixel, end_frame: 1'b0};
        cand[1] = '{row: i_stage.pos.row_prev, column: i_stage.pos.col_prev,
                    value: blur, end_frame: 1'b0};
        cand[2] = '{row: i_stage.pos.row_prev, column: i_stage.pos.col_cur,
                    value: i_stage.mid, end_frame: 1'b0};
        cand[3] = '{row: i_stage.pos.row_cur, column: '0,
                    value: i_stage.left_pixel, end_frame: 1'b0};
        cand[4] = '{row: i_stage.pos.row_cur, column: i_stage.pos.col_cur,
                    value: i_stage.pixel, end_frame: i_stage.flags.end_frame};
        cand_en = {i_stage.flags.last_row, i_stage.flags.left_edge,
                   i_stage.flags.right_edge, i_stage.flags.interior,
                   i_stage.flags.first_row};

        rec = '0;
        n   = '0;
        for (int k = 0; k < 5; k++) begin
            if (cand_en[k]) begin
                rec.slot[n] = cand[k];
                n = n + 2'd1;
            end
        end
        rec.cnt = n;
    end

    assign push = i_stage.valid && (rec.cnt != '0);

    assign head    = r_q[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_res   = head.slot[r_sub];
    assign o_last  = (r_sub == head.cnt - 2'd1);
    assign xfer    = o_valid && !i_stall;
    assign pop     = xfer && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_sub <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd  <= r_rd + 1'b1;
                r_sub <= '0;
            end else if (xfer) begin
                r_sub <= r_sub + 2'd1;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= rec;
        end
    end

    assign o_count = r_cnt;

endmodule

`default_nettype wire

### hdl/box_blur_3x3_stream.sv
// Results of a pixel pass the read stage, the window stage register and the
// result queue, behind any older records, before the first of them is offered.
// Throughput: one pixel and one result per cycle while no stall is raised.
// Row-end bursts of three fit in the queue; on the last row each pixel gives
// two results, so the queue fills and the pixel input is stalled there.
// Reset: frame size 640 x 480; counters, window and queue cleared, line stores kept.
// ----------------------------------------------------------------------------
// box_blur_3x3_stream: streaming 3x3 mean filter for 8-bit grey pixels
// Pixels arrive in raster order; every pixel of the frame leaves exactly once
// with its row and column, interior pixels averaged, border pixels copied.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_stream #(
    parameter int MAX_WIDTH  = bbl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbl_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Pixel input channel.
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [bbl_pkg::PIX_W-1:0]     i_pixel,
    // Result output channel.
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [bbl_pkg::POS_W-1:0]     o_out_row,
    output logic      [bbl_pkg::POS_W-1:0]     o_out_column,
    output logic      [bbl_pkg::PIX_W-1:0]     o_value,
    output logic                               o_last_of_run,
    output logic                               o_end_of_frame,
    // Configuration write channel.
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bbl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bbl_pkg::CFG_W-1:0]     i_cfg_data
);

    import bbl_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // A size below three acts as three, one above the maximum as the maximum.
    // The registers keep the clamped size minus one, the last column or row.
    function automatic int clamp_m1(input logic [CFG_W-1:0] v, input int hi);
        int val;
        val = int'(v);
        if (val < 3) begin
            return 2;
        end
        if (val > hi) begin
            return hi - 1;
        end
        return val - 1;
    endfunction

    logic [CW-1:0]    r_wm1;
    logic [RW-1:0]    r_hm1;
    logic             accept;
    t_stage           stage;
    logic [1:0]       inflight;
    logic [CNT_W-1:0] q_count;
    logic [OCC_W-1:0] occupancy;
    t_res             res;

    // The configuration port takes a write in every cycle. The user is to write only
    // while the pipeline is empty, so no in-flight pixel sees a change (not enforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1 <= CW'(clamp_m1(FRAME_WIDTH_RST, MAX_WIDTH));
            r_hm1 <= RW'(clamp_m1(FRAME_HEIGHT_RST, MAX_HEIGHT));
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:  r_wm1 <= CW'(clamp_m1(i_cfg_data, MAX_WIDTH));
                REG_FRAME_HEIGHT: r_hm1 <= RW'(clamp_m1(i_cfg_data, MAX_HEIGHT));
            endcase
        end
    end

    // Flow control by reservation: every pixel in the two pipeline stages
    // owns one queue record, so a pixel is taken only while the queue plus
    // the pipeline leave a free record. The stall does not look at the
    // output side in the same cycle, which keeps the two channels apart.
    assign occupancy  = OCC_W'(q_count) + OCC_W'(inflight);
    assign o_in_stall = (occupancy >= OCC_W'(Q_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    // Counters, line stores and window: read in the transfer cycle,
    // window shift, write-back and sum in the cycle after.
    bbl_line_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_line_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_pixel    (i_pixel),
        .i_wm1      (r_wm1),
        .i_hm1      (r_hm1),
        .o_stage    (stage),
        .o_inflight (inflight)
    );

    // Division by nine, result packing and the output queue.
    bbl_result_queue u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (stage),
        .o_count (q_count),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (res),
        .o_last  (o_last_of_run)
    );

    assign o_out_row      = res.row;
    assign o_out_column   = res.column;
    assign o_value        = res.value;
    assign o_end_of_frame = res.end_frame;

endmodule

`default_nettype wire

### bench/box_blur_3x3_checker.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_checker: result predictor and scoreboard for the box blur
// Watches the pixel, result and register channels of the blur block, keeps
// its own line stores, window and counters, and compares every result
// transfer field by field with the oldest predicted output pixel.
// ----------------------------------------------------------------------------
module box_blur_3x3_checker #(
    parameter int MAX_WIDTH  = bbl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbl_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire logic [bbl_pkg::PIX_W-1:0]     i_pixel,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [bbl_pkg::POS_W-1:0]     i_out_row,
    input  wire logic [bbl_pkg::POS_W-1:0]     i_out_column,
    input  wire logic [bbl_pkg::PIX_W-1:0]     i_value,
    input  wire logic                          i_last_of_run,
    input  wire logic                          i_end_of_frame,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [bbl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bbl_pkg::CFG_W-1:0]     i_cfg_data,
    output int                                 o_mismatches,
    output int                                 o_pending
);
    import bbl_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic [PIX_W-1:0] value;
        logic             last_of_run;
        logic             end_of_frame;
    } t_blur_px;

    t_blur_px         awaited_px_q[$];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] row_two_up [MAX_WIDTH];
    logic [PIX_W-1:0] row_one_up [MAX_WIDTH];
    logic [PIX_W-1:0] win [9];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int               mismatches = 0;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_blur_px make_px(input int unsigned r, input int unsigned c,
                                         input int unsigned v, input logic eof);
        t_blur_px p;
        p.row          = POS_W'(r);
        p.column       = POS_W'(c);
        p.value        = PIX_W'(v);
        p.last_of_run  = 1'b0;
        p.end_of_frame = eof;
        return p;
    endfunction

    // Works out the output pixels that one accepted source pixel releases.
    task automatic predict_pixel(input logic [PIX_W-1:0] px);
        t_blur_px         burst [3];
        int               n;
        int               i;
        int unsigned      w;
        int unsigned      h;
        int unsigned      x;
        int unsigned      y;
        int unsigned      sum;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        n = 0;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        // A size change in the middle of a frame pins the counters to the new edge.
        if (col_pos > w - 1) col_pos = w - 1;
        if (row_pos > h - 1) row_pos = h - 1;
        x = col_pos;
        y = row_pos;

        top = row_two_up[x];
        mid = row_one_up[x];
        for (i = 0; i < 3; i++) begin
            win[3*i]   = win[3*i+1];
            win[3*i+1] = win[3*i+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        row_two_up[x] = mid;
        row_one_up[x] = px;

        if (y == 0) begin
            burst[n] = make_px(0, x, px, 1'b0);
            n++;
        end else begin
            if (y >= 2 && x >= 2) begin
                sum = 4;
                for (i = 0; i < 9; i++) sum += win[i];
                burst[n] = make_px(y - 1, x - 1, sum / 9, 1'b0);
                n++;
            end
            if (y >= 2 && x == w - 1) begin
                burst[n] = make_px(y - 1, w - 1, mid, 1'b0);
                n++;
            end
            if (y <= h - 2 && x == w - 1) begin
                burst[n] = make_px(y, 0, row_one_up[0], 1'b0);
                n++;
            end
            if (y == h - 1) begin
                burst[n] = make_px(y, x, px, x == w - 1);
                n++;
            end
        end
        if (n > 0) burst[n-1].last_of_run = 1'b1;
        for (i = 0; i < n; i++) awaited_px_q.push_back(burst[i]);

        if (x >= w - 1) begin
            col_pos = 0;
            row_pos = (y >= h - 1) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_blur_px want;
        int       k;
        if (!i_rst_n) begin
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            for (k = 0; k < MAX_WIDTH; k++) begin
                row_two_up[k] = '0;
                row_one_up[k] = '0;
            end
            for (k = 0; k < 9; k++) win[k] = '0;
            col_pos = 0;
            row_pos = 0;
            awaited_px_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_px_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual row %0d column %0d value %0d",
                             $time, i_out_row, i_out_column, i_value);
                    mismatches++;
                end else begin
                    want = awaited_px_q.pop_front();
                    check_field("row", want.row, i_out_row);
                    check_field("column", want.column, i_out_column);
                    check_field("value", want.value, i_value);
                    check_field("last_of_run", want.last_of_run, i_last_of_run);
                    check_field("end_of_frame", want.end_of_frame, i_end_of_frame);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_FRAME_WIDTH: begin
                        width_reg = i_cfg_data;
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_pixel(i_pixel);
        end
        o_pending    <= awaited_px_q.size();
        o_mismatches <= mismatches;
    end

endmodule

### bench/box_blur_3x3_stream_tb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_tb: stimulus and verdict for the 3x3 box blur stream
// Streams grey frames of many sizes through the block, from the smallest
// clamped frame to the widest one, resizes frames while a frame is in
// flight, and lets a separate checker predict and compare every result.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_tb;
    import bbl_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    // Far above the slowest correct run.
    localparam int LIMIT_CYCLES   = 2_000_000;
    // Room for the two-stage pipeline to empty out after the last result.
    localparam int SETTLE_CYCLES  = 10;
    localparam int RESET_RUN      = 40;
    localparam int WIDE_RUN       = 100;
    localparam int RANDOM_PIXELS  = 180;
    localparam int IDLE_PERCENT   = 14;
    localparam int HOLD_AT_RESULT = 20;
    localparam int HOLD_CYCLES    = 300;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 pix_valid = 1'b0;
    logic [PIX_W-1:0]     pix_data  = '0;
    logic                 res_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    // While set, neither side idles: a long stretch at full rate.
    logic                 calm      = 1'b0;

    logic                 in_stall;
    logic                 out_valid;
    logic [POS_W-1:0]     out_row;
    logic [POS_W-1:0]     out_column;
    logic [PIX_W-1:0]     out_value;
    logic                 out_last;
    logic                 out_eof;
    logic                 cfg_ready;
    int                   mismatches;
    int                   pending;

    box_blur_3x3_stream dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (pix_valid),
        .o_in_stall     (in_stall),
        .i_pixel        (pix_data),
        .o_out_valid    (out_valid),
        .i_out_stall    (res_stall),
        .o_out_row      (out_row),
        .o_out_column   (out_column),
        .o_value        (out_value),
        .o_last_of_run  (out_last),
        .o_end_of_frame (out_eof),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    box_blur_3x3_checker blur_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (pix_valid),
        .i_in_stall     (in_stall),
        .i_pixel        (pix_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (res_stall),
        .i_out_row      (out_row),
        .i_out_column   (out_column),
        .i_value        (out_value),
        .i_last_of_run  (out_last),
        .i_end_of_frame (out_eof),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Source pixels lean toward the extremes so that saturated sums show up.
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Offers one pixel and returns right after the edge of its transfer. Valid
    // is left high, so back-to-back pixels never drop it within one step; any
    // idle gap lowers it first, in a step of its own.
    task automatic send_pixel(input logic [PIX_W-1:0] p);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_run(input int unsigned n);
        repeat (n) send_pixel(pick_pixel());
    endtask

    // Stops the pixel stream and waits until every predicted result has been
    // taken. The first edge lets the checker count the last transfer; the
    // settle time covers pixels that release no result at all.
    task automatic drain_stream();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both size registers while the block is idle. Valid stays high
    // between the two transfers.
    task automatic set_frame_size(input int unsigned w, input int unsigned h);
        drain_stream();
        cfg_valid <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side. It stalls at random, except during the calm stretch, and
    // once, early in the run, holds off for a long stretch so that the result
    // queue fills and the block has to stall the pixel stream.
    initial begin : result_sink
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && !res_stall) taken++;
            if (!held && taken >= HOLD_AT_RESULT) begin
                held = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    initial begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned raw_w;
        int unsigned raw_h;
        int unsigned r;
        int unsigned c;
        int unsigned nw;
        int unsigned nh;
        int unsigned sent;
        int          i;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Run at the size left by reset: part of the first 640-pixel row. Then
        // shrink both sizes in the middle of the row; the next pixel lands on
        // the clamped last column and two more rows close the 5 x 3 frame.
        send_run(RESET_RUN);
        set_frame_size(5, 3);
        send_run(2 * 5 + 1);

        // Register values below the legal range act as the 3x3 minimum. An all
        // white frame checks the largest window sum, a checkerboard the mix
        // of border copies and averages.
        set_frame_size(0, 1);
        repeat (9) send_pixel('1);
        set_frame_size(3, 2);
        for (i = 0; i < 9; i++) send_pixel((i % 2 != 0) ? '1 : '0);

        // The widest frame, reached through an all-ones width, runs with no
        // idling on either side. Part of its first row goes in, then the frame
        // shrinks and closes at 5 x 3.
        calm <= 1'b1;
        set_frame_size(8191, 0);
        send_run(WIDE_RUN);
        set_frame_size(5, 3);
        send_run(2 * 5 + 1);
        calm <= 1'b0;

        // Random small frames. Some are resized part way through: only after
        // two whole rows, and never wider, so that every window is built from
        // line store entries written in this frame.
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            w = $urandom_range(9, 3);
            h = $urandom_range(7, 3);
            raw_w = (w == 3 && $urandom_range(1) == 0) ? $urandom_range(2, 0) : w;
            raw_h = (h == 3 && $urandom_range(1) == 0) ? $urandom_range(2, 0) : h;
            set_frame_size(raw_w, raw_h);
            if ($urandom_range(3) == 0) begin
                r = $urandom_range(h - 1, 2);
                c = $urandom_range(w - 1, 0);
                send_run(r * w + c);
                sent += r * w + c;
                nw = $urandom_range(w, 3);
                nh = $urandom_range(h + 2, 3);
                set_frame_size(nw, nh);
                // Where the block's counters stand once they are clamped.
                r = (r > nh - 1) ? nh - 1 : r;
                c = (c > nw - 1) ? nw - 1 : c;
                send_run((nh - 1 - r) * nw + nw - c);
                sent += (nh - 1 - r) * nw + nw - c;
            end else begin
                send_run(w * h);
                sent += w * h;
            end
        end

        drain_stream();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

endmodule
